>>> hw/rtl/aidtm_pkg.sv
// Shared types, codes and reset constants for the accessory ID classifier.
// No dependencies; every other file refers to this package by scoped names.
package aidtm_pkg;

    localparam int SAMPLES_DEF  = 5;
    localparam int ADC_BITS_DEF = 12;

    localparam int FIELD_BITS = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = 12'hFFF;

    localparam logic [1:0] TYPE_NONE    = 2'd0;
    localparam logic [1:0] TYPE_OTG     = 2'd1;
    localparam logic [1:0] TYPE_LINEOUT = 2'd2;
    localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

    localparam logic [1:0] OTG_KEEP    = 2'd0;
    localparam logic [1:0] OTG_ENABLE  = 2'd1;
    localparam logic [1:0] OTG_DISABLE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINEOUT_LOW_A  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINEOUT_HIGH_A = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINEOUT_LOW_B  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINEOUT_HIGH_B = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OTG_LOW        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OTG_HIGH       = 3'd5;

    localparam logic [FIELD_BITS-1:0] RST_LINEOUT_LOW_A  = 12'd1100;
    localparam logic [FIELD_BITS-1:0] RST_LINEOUT_HIGH_A = 12'd1400;
    localparam logic [FIELD_BITS-1:0] RST_LINEOUT_LOW_B  = 12'd1800;
    localparam logic [FIELD_BITS-1:0] RST_LINEOUT_HIGH_B = 12'd2350;
    localparam logic [FIELD_BITS-1:0] RST_OTG_LOW        = 12'd2450;
    localparam logic [FIELD_BITS-1:0] RST_OTG_HIGH       = 12'd2850;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]            acc_class;
        logic                  online;
        logic [FIELD_BITS-1:0] id_level;
        logic                  ear_jack;
        logic [1:0]            otg_action;
    } t_out_beat;

    typedef struct packed {
        logic [FIELD_BITS-1:0] lineout_low_a;
        logic [FIELD_BITS-1:0] lineout_high_a;
        logic [FIELD_BITS-1:0] lineout_low_b;
        logic [FIELD_BITS-1:0] lineout_high_b;
        logic [FIELD_BITS-1:0] otg_window_low;
        logic [FIELD_BITS-1:0] otg_window_high;
    } t_windows;

endpackage

>>> hw/rtl/aidtm_acc.sv
// Sample gathering stage: running sum, min and max, trimmed-sum token register.
// Depends on aidtm_pkg.
module aidtm_acc #(
    parameter int SAMPLES  = aidtm_pkg::SAMPLES_DEF,
    parameter int ADC_BITS = aidtm_pkg::ADC_BITS_DEF,
    localparam int CW = $clog2(SAMPLES),
    localparam int SW = ADC_BITS + $clog2(SAMPLES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aidtm_pkg::t_in_beat i_in_data,
    output logic                o_tok_valid,
    input  logic                i_tok_ready,
    output logic                o_tok_detach,
    output logic [SW-1:0]       o_tok_trim
);

    logic [CW-1:0]       r_count;
    logic [SW-1:0]       r_sum;
    logic [ADC_BITS-1:0] r_low;
    logic [ADC_BITS-1:0] r_high;
    logic                r_tok_valid;
    logic                r_tok_detach;
    logic [SW-1:0]       r_tok_trim;

    logic                accept;
    logic                first;
    logic                last;
    logic [ADC_BITS-1:0] s;
    logic [ADC_BITS-1:0] n_low;
    logic [ADC_BITS-1:0] n_high;
    logic [SW-1:0]       n_sum;
    logic [SW-1:0]       trim;

    assign o_in_ready = !r_tok_valid || i_tok_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign s      = ADC_BITS'(i_in_data.sample);
    assign first  = (r_count == '0);
    assign last   = (r_count == CW'(SAMPLES - 1));
    assign n_low  = (first || (s < r_low))  ? s : r_low;
    assign n_high = (first || (s > r_high)) ? s : r_high;
    assign n_sum  = r_sum + SW'(s);
    assign trim   = n_sum - SW'(n_low) - SW'(n_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_low   <= '0;
            r_high  <= '0;
        end else if (accept) begin
            if (i_in_data.kind || last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_low   <= '0;
                r_high  <= '0;
            end else begin
                r_count <= r_count + CW'(1);
                r_sum   <= n_sum;
                r_low   <= n_low;
                r_high  <= n_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_tok_valid <= accept && (i_in_data.kind || last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_tok_detach <= i_in_data.kind;
            r_tok_trim   <= trim;
        end
    end

    assign o_tok_valid  = r_tok_valid;
    assign o_tok_detach = r_tok_detach;
    assign o_tok_trim   = r_tok_trim;

endmodule

>>> hw/rtl/aidtm_div.sv
// Divide the trimmed sum by SAMPLES-2 through a registered reciprocal product.
// Depends on aidtm_pkg for parameter defaults.
module aidtm_div #(
    parameter int SAMPLES  = aidtm_pkg::SAMPLES_DEF,
    parameter int ADC_BITS = aidtm_pkg::ADC_BITS_DEF,
    localparam int SW = ADC_BITS + $clog2(SAMPLES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    output logic                o_tok_ready,
    input  logic                i_tok_detach,
    input  logic [SW-1:0]       i_tok_trim,
    output logic                o_mean_valid,
    input  logic                i_mean_ready,
    output logic                o_mean_detach,
    output logic [ADC_BITS-1:0] o_mean
);

    localparam int DIV = SAMPLES - 2;
    localparam int SH  = SW + $clog2(DIV);
    localparam int MB  = SW + 2;
    localparam int PW  = SW + MB;
    localparam logic [MB-1:0] RECIP = MB'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic          r_valid;
    logic          r_detach;
    logic [PW-1:0] r_prod;

    assign o_tok_ready = !r_valid || i_mean_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tok_ready) begin
            r_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_ready) begin
            r_detach <= i_tok_detach;
            r_prod   <= PW'(i_tok_trim) * PW'(RECIP);
        end
    end

    assign o_mean_valid  = r_valid;
    assign o_mean_detach = r_detach;
    assign o_mean        = r_prod[SH +: ADC_BITS];

endmodule

>>> hw/rtl/aidtm_cls.sv
// Window classifier, accessory type and ear-jack state, and the result register.
// Depends on aidtm_pkg.
module aidtm_cls #(
    parameter int ADC_BITS = aidtm_pkg::ADC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aidtm_pkg::t_windows  i_win,
    input  logic                 i_mean_valid,
    output logic                 o_mean_ready,
    input  logic                 i_mean_detach,
    input  logic [ADC_BITS-1:0]  i_mean,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output aidtm_pkg::t_out_beat o_out_data
);

    localparam int FB = aidtm_pkg::FIELD_BITS;
    localparam int LW = (ADC_BITS > FB) ? ADC_BITS : FB;

    logic                 r_out_valid;
    aidtm_pkg::t_out_beat r_out;
    logic [1:0]           r_type;
    logic                 r_ear;

    aidtm_pkg::t_out_beat n_out;
    logic [1:0]           n_type;
    logic                 n_ear;
    logic                 load;
    logic                 det;
    logic                 hit_a;
    logic                 hit_b;
    logic                 hit_otg;
    logic [LW-1:0]        m;

    assign o_mean_ready = !r_out_valid || i_out_ready;
    assign load         = i_mean_valid && o_mean_ready;

    assign m       = LW'(i_mean);
    assign det     = i_mean_detach || (i_mean == '0);
    assign hit_a   = (LW'(i_win.lineout_low_a) < m) && (m < LW'(i_win.lineout_high_a));
    assign hit_b   = (LW'(i_win.lineout_low_b) < m) && (m < LW'(i_win.lineout_high_b));
    assign hit_otg = (LW'(i_win.otg_window_low) < m) && (m < LW'(i_win.otg_window_high));

    always_comb begin
        n_type = r_type;
        n_ear  = r_ear;
        n_out.online     = 1'b0;
        n_out.id_level   = '0;
        n_out.otg_action = aidtm_pkg::OTG_KEEP;
        if (det) begin
            n_type = aidtm_pkg::TYPE_NONE;
            if (r_type == aidtm_pkg::TYPE_LINEOUT) begin
                n_ear = 1'b0;
            end
            if (r_type == aidtm_pkg::TYPE_OTG) begin
                n_out.otg_action = aidtm_pkg::OTG_DISABLE;
            end
            n_out.acc_class = r_type;
        end else begin
            priority if (hit_a || hit_b) begin
                n_type = aidtm_pkg::TYPE_LINEOUT;
                n_ear  = 1'b1;
            end else if (hit_otg) begin
                n_type           = aidtm_pkg::TYPE_OTG;
                n_out.otg_action = aidtm_pkg::OTG_ENABLE;
            end else begin
                n_type = aidtm_pkg::TYPE_UNKNOWN;
            end
            n_out.acc_class = n_type;
            n_out.online    = 1'b1;
            n_out.id_level = (m > LW'(aidtm_pkg::FIELD_MAX)) ? aidtm_pkg::FIELD_MAX
                                                             : m[FB-1:0];
        end
        n_out.ear_jack = n_ear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_type      <= aidtm_pkg::TYPE_NONE;
            r_ear       <= 1'b0;
        end else begin
            if (o_mean_ready) begin
                r_out_valid <= i_mean_valid;
            end
            if (load) begin
                r_type <= n_type;
                r_ear  <= n_ear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/accessory_id_trimmed_mean_classifier_core.sv
// Top level of the accessory ID classifier: window registers and the three stages.
// Depends on aidtm_pkg, aidtm_acc, aidtm_div and aidtm_cls.
//
// Input beats carry either an ID-line ADC sample (kind 0) or a detach event (kind 1).
// SAMPLES samples are gathered; the mean of all but the smallest and largest is
// checked against the line-out A, line-out B and OTG windows, and one report beat
// goes out. A detach event, or a mean of zero, yields an offline report for the
// stored type and drops any partial set of samples.
// Window bounds are written on the configuration channel at index 0..5; it is
// always ready and other indexes are ignored.
// Throughput: one input beat per cycle while o_in_ready is high, set by the sum, min
// and max update. The token register loads at the edge that accepts the causing beat;
// the report then passes the reciprocal product register and the result register
// before it is valid.
// Reset clears the gathering state, the type and the ear-jack level and loads the
// default window bounds; no report is pending after reset.
// When the receiver stalls, the stages fill one by one; o_in_ready falls only
// once all three hold an unsent report.
module accessory_id_trimmed_mean_classifier_core #(
    parameter int SAMPLES  = aidtm_pkg::SAMPLES_DEF,
    parameter int ADC_BITS = aidtm_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  aidtm_pkg::t_in_beat                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output aidtm_pkg::t_out_beat                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aidtm_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [aidtm_pkg::FIELD_BITS-1:0]    i_cfg_data
);

    localparam int SW = ADC_BITS + $clog2(SAMPLES);

    aidtm_pkg::t_windows r_win;

    logic                tok_valid;
    logic                tok_ready;
    logic                tok_detach;
    logic [SW-1:0]       tok_trim;
    logic                mean_valid;
    logic                mean_ready;
    logic                mean_detach;
    logic [ADC_BITS-1:0] mean;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.lineout_low_a   <= aidtm_pkg::RST_LINEOUT_LOW_A;
            r_win.lineout_high_a  <= aidtm_pkg::RST_LINEOUT_HIGH_A;
            r_win.lineout_low_b   <= aidtm_pkg::RST_LINEOUT_LOW_B;
            r_win.lineout_high_b  <= aidtm_pkg::RST_LINEOUT_HIGH_B;
            r_win.otg_window_low  <= aidtm_pkg::RST_OTG_LOW;
            r_win.otg_window_high <= aidtm_pkg::RST_OTG_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                aidtm_pkg::CFG_LINEOUT_LOW_A:  r_win.lineout_low_a   <= i_cfg_data;
                aidtm_pkg::CFG_LINEOUT_HIGH_A: r_win.lineout_high_a  <= i_cfg_data;
                aidtm_pkg::CFG_LINEOUT_LOW_B:  r_win.lineout_low_b   <= i_cfg_data;
                aidtm_pkg::CFG_LINEOUT_HIGH_B: r_win.lineout_high_b  <= i_cfg_data;
                aidtm_pkg::CFG_OTG_LOW:        r_win.otg_window_low  <= i_cfg_data;
                aidtm_pkg::CFG_OTG_HIGH:       r_win.otg_window_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    aidtm_acc #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_BITS)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_tok_valid  (tok_valid),
        .i_tok_ready  (tok_ready),
        .o_tok_detach (tok_detach),
        .o_tok_trim   (tok_trim)
    );

    aidtm_div #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_BITS)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (tok_valid),
        .o_tok_ready   (tok_ready),
        .i_tok_detach  (tok_detach),
        .i_tok_trim    (tok_trim),
        .o_mean_valid  (mean_valid),
        .i_mean_ready  (mean_ready),
        .o_mean_detach (mean_detach),
        .o_mean        (mean)
    );

    aidtm_cls #(
        .ADC_BITS (ADC_BITS)
    ) u_cls (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win         (r_win),
        .i_mean_valid  (mean_valid),
        .o_mean_ready  (mean_ready),
        .i_mean_detach (mean_detach),
        .i_mean        (mean),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

>>> hw/rtl/aidtm_checker.sv
// Port-level checks on the accessory ID classifier, bound to the top level.
// Depends on aidtm_pkg and accessory_id_trimmed_mean_classifier_core.
module aidtm_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  aidtm_pkg::t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat pending right after reset");

    a_offline_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.online |-> o_out_data.id_level == '0 &&
        o_out_data.otg_action != aidtm_pkg::OTG_ENABLE)
        else $error("offline report with level or OTG enable");

    a_online_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.online |->
        o_out_data.acc_class != aidtm_pkg::TYPE_NONE &&
        o_out_data.otg_action != aidtm_pkg::OTG_DISABLE)
        else $error("online report with no type or OTG disable");

    a_lineout_jack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.online &&
        o_out_data.acc_class == aidtm_pkg::TYPE_LINEOUT |-> o_out_data.ear_jack)
        else $error("line-out report without ear jack");

endmodule

bind accessory_id_trimmed_mean_classifier_core aidtm_checker u_aidtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
